// File: design/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants of the odometry unit
// word widths, register indexes, cordic tables and the front-to-back record
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int CountW = 32;
	localparam int SpeedW = 24;
	localparam int PosW   = 32;
	localparam int HeadW  = 16;
	localparam int AngW   = 32;
	localparam int CfgW   = 32;
	localparam int CfgIdxW = 2;
	localparam int AtanEntries = 24;

	localparam logic [CfgIdxW-1:0] RegDistPerPulse = 2'd0;
	localparam logic [CfgIdxW-1:0] RegTurnsPerDist = 2'd1;
	localparam logic [CfgIdxW-1:0] RegInvWheelBase = 2'd2;

	localparam logic signed [33:0] CordicGain = 34'sd652032874;

	// front-to-back record: deltas and speeds of one tick
	typedef struct packed {
		logic signed [CountW-1:0] d_right;
		logic signed [CountW-1:0] d_left;
		logic signed [SpeedW-1:0] right_speed;
		logic signed [SpeedW-1:0] left_speed;
	} tick_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

// File: design/diff_drive_odometry_unit.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_unit: differential-drive wheel odometry
// wheel counts and speeds in, pose and body speeds out
// ----------------------------------------------------------------------------
// Each pushed tick gives one result. The front takes the transfer at once,
// forms wrapped count deltas and puts them in a two-entry queue. The back
// works on one tick at a time: eight multiply steps on one shared multiplier
// and CORDIC_STEPS cordic iterations. The result stays on the ports until
// popped; the back goes idle on the pop and takes the next tick from the
// idle state, so it does not start a new tick before the last result is
// popped. Configuration writes take effect at once and are meant for idle.
module diff_drive_odometry_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] right_count,
	input  logic signed [31:0] left_count,
	input  logic signed [23:0] right_speed,
	input  logic signed [23:0] left_speed,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] x_position,
	output logic signed [31:0] y_position,
	output logic [15:0]        heading,
	output logic signed [23:0] linear_speed,
	output logic signed [31:0] angular_speed,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ddo_pkg::*;

	logic [31:0] dpp_q, tpd_q, iwb_q;
	tick_t tick_in, tick_out;
	logic q_empty, busy, res_valid, take;

	// configuration registers, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpp_q <= 32'd65;
			tpd_q <= 32'd65536;
			iwb_q <= 32'd327680;
		end else if (cfg_we) begin
			priority if (cfg_index == RegDistPerPulse) dpp_q <= cfg_data;
			else if (cfg_index == RegTurnsPerDist) tpd_q <= cfg_data;
			else if (cfg_index == RegInvWheelBase) iwb_q <= cfg_data;
		end
	end

	assign take = push && !full;

	ddo_front u_front (
		.clk, .arst_n, .take,
		.right_count, .left_count, .right_speed, .left_speed,
		.tick(tick_in)
	);

	// back pulls the next tick whenever it is idle
	ddo_queue u_queue (
		.clk, .arst_n, .push(take), .wdata(tick_in), .full,
		.pop(!busy), .empty(q_empty), .rdata(tick_out)
	);

	ddo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .start(!q_empty), .tick(tick_out), .busy,
		.dist_per_pulse(dpp_q), .turns_per_dist(tpd_q), .inv_wheel_base(iwb_q),
		.res_valid, .res_pop(pop),
		.x_position, .y_position, .heading, .linear_speed, .angular_speed
	);

	assign empty = !res_valid;

	// a popped result leaves the output empty on the next edge
	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty |=> empty) else $error("result not cleared after pop");
	// heading only moves while a tick is in the back
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> $stable(heading) || busy) else $error("heading moved while idle");
	// x and y positions hold until popped
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(x_position) && $stable(y_position))
		else $error("result changed before pop");
endmodule

// File: design/ddo_front.sv
// ----------------------------------------------------------------------------
// ddo_front: input side of the odometry unit
// takes count transfers, forms wrapped deltas and keeps the last counts
// ----------------------------------------------------------------------------
module ddo_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic signed [31:0]          right_count,
	input  logic signed [31:0]          left_count,
	input  logic signed [23:0]          right_speed,
	input  logic signed [23:0]          left_speed,
	output ddo_pkg::tick_t              tick
);
	import ddo_pkg::*;

	logic [CountW-1:0] last_right_q;
	logic [CountW-1:0] last_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_right_q <= '0;
			last_left_q  <= '0;
		end else if (take) begin
			last_right_q <= right_count;
			last_left_q  <= left_count;
		end
	end

	// modular deltas, read signed
	always_comb begin
		tick.d_right     = right_count - last_right_q;
		tick.d_left      = left_count - last_left_q;
		tick.right_speed = right_speed;
		tick.left_speed  = left_speed;
	end
endmodule

// File: design/ddo_queue.sv
// ----------------------------------------------------------------------------
// ddo_queue: two-entry queue between front and back
// registered entries with head and tail pointers
// ----------------------------------------------------------------------------
module ddo_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ddo_pkg::tick_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output ddo_pkg::tick_t rdata
);
	import ddo_pkg::*;

	tick_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end
endmodule

// File: design/ddo_back.sv
// ----------------------------------------------------------------------------
// ddo_back: pose engine of the odometry unit
// sequencer with one shared multiplier and an iterative cordic
// ----------------------------------------------------------------------------
module ddo_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ddo_pkg::tick_t       tick,
	output logic                 busy,
	input  logic [31:0]          dist_per_pulse,
	input  logic [31:0]          turns_per_dist,
	input  logic [31:0]          inv_wheel_base,
	output logic                 res_valid,
	input  logic                 res_pop,
	output logic signed [31:0]   x_position,
	output logic signed [31:0]   y_position,
	output logic [15:0]          heading,
	output logic signed [23:0]   linear_speed,
	output logic signed [31:0]   angular_speed
);
	import ddo_pkg::*;

	localparam int StepW = $clog2(CORDIC_STEPS + 1);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_HMUL1 = 11'b00000000010,
		ST_HMUL2 = 11'b00000000100,
		ST_SMUL  = 11'b00000001000,
		ST_CORD  = 11'b00000010000,
		ST_XMUL  = 11'b00000100000,
		ST_XHI   = 11'b00001000000,
		ST_YMUL  = 11'b00010000000,
		ST_YHI   = 11'b00100000000,
		ST_AMUL  = 11'b01000000000,
		ST_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;
	tick_t  tick_q;
	logic [31:0] tmp_q, sum_q;
	logic [30:0] sumh_q;
	logic [15:0] head_q;
	logic [StepW-1:0] step_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic flip_q;
	logic [31:0] px_q, py_q;

	// shared 33x34 signed multiplier
	logic signed [32:0] ma;
	logic signed [33:0] mb;
	logic signed [66:0] mp;
	assign mp = ma * mb;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_HMUL1: begin
				ma = {1'b0, tick_q.d_left - tick_q.d_right};
				mb = {2'b0, dist_per_pulse};
			end
			ST_HMUL2: begin
				ma = {1'b0, tmp_q};
				mb = {2'b0, turns_per_dist};
			end
			ST_SMUL: begin
				// full signed sum of the deltas
				ma = {tick_q.d_right[31], tick_q.d_right}
					+ {tick_q.d_left[31], tick_q.d_left};
				mb = {2'b0, dist_per_pulse};
			end
			ST_XMUL: begin
				ma = {1'b0, sum_q};
				mb = flip_q ? -cx_q : cx_q;
			end
			ST_XHI: begin
				ma = {2'b0, sumh_q};
				mb = flip_q ? -cx_q : cx_q;
			end
			ST_YMUL: begin
				ma = {1'b0, sum_q};
				mb = flip_q ? -cy_q : cy_q;
			end
			ST_YHI: begin
				ma = {2'b0, sumh_q};
				mb = flip_q ? -cy_q : cy_q;
			end
			ST_AMUL: begin
				ma = 33'(signed'({tick_q.right_speed[23], tick_q.right_speed})
					- signed'({tick_q.left_speed[23], tick_q.left_speed}));
				mb = {2'b0, inv_wheel_base};
			end
			default: ;
		endcase
	end

	logic [4:0] sh;
	assign sh = 5'(step_q);
	logic signed [33:0] dx, dy;
	assign dx = cy_q >>> sh;
	assign dy = cx_q >>> sh;
	logic signed [33:0] at;
	assign at = {2'b0, atan_turn(sh)};

	logic [31:0] ang0;
	assign ang0 = {head_q, 16'b0};
	logic flip0;
	assign flip0 = (ang0[31:30] == 2'b01) || (ang0[31:30] == 2'b10);
	logic [31:0] ang1;
	assign ang1 = flip0 ? ang0 - 32'h80000000 : ang0;

	logic signed [50:0] aw;
	assign aw = mp[66:16];

	assign busy = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign x_position = px_q;
	assign y_position = py_q;
	assign heading = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			px_q    <= '0;
			py_q    <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) begin
					tick_q  <= tick;
					state_q <= ST_HMUL1;
				end
				ST_HMUL1: begin
					tmp_q   <= mp[31:0];
					state_q <= ST_HMUL2;
				end
				ST_HMUL2: begin
					head_q  <= head_q + mp[31:16];
					state_q <= ST_SMUL;
				end
				ST_SMUL: begin
					sum_q   <= mp[31:0];
					sumh_q  <= mp[62:32];
					flip_q  <= flip0;
					cx_q    <= CordicGain;
					cy_q    <= '0;
					cz_q    <= 34'(signed'(ang1));
					step_q  <= '0;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + at;
					end
					step_q <= step_q + 1'b1;
					if (step_q == StepW'(CORDIC_STEPS - 1)) state_q <= ST_XMUL;
				end
				// low word of the distance sum, then the upper word shifted up
				ST_XMUL: begin
					px_q    <= px_q + mp[62:31];
					state_q <= ST_XHI;
				end
				ST_XHI: begin
					px_q    <= px_q + {mp[30:0], 1'b0};
					state_q <= ST_YMUL;
				end
				ST_YMUL: begin
					py_q    <= py_q + mp[62:31];
					state_q <= ST_YHI;
				end
				ST_YHI: begin
					py_q    <= py_q + {mp[30:0], 1'b0};
					state_q <= ST_AMUL;
				end
				ST_AMUL: begin
					// saturate to signed 32 bits
					if (aw > 51'sd2147483647) angular_speed <= 32'h7FFFFFFF;
					else if (aw < -51'sd2147483648) angular_speed <= 32'h80000000;
					else angular_speed <= aw[31:0];
					linear_speed <= 24'((25'(tick_q.right_speed)
						+ 25'(tick_q.left_speed)) >>> 1);
					state_q <= ST_DONE;
				end
				ST_DONE: if (res_pop) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression of diff_drive_odometry_unit
// random and directed odometry ticks against a cycle-free pose predictor
// ----------------------------------------------------------------------------
// A driver offers ticks from a queue that the stimulus process fills. The pose
// predictor runs on each accepted transfer and stores the expected result. A
// monitor pops results and compares every field with the oldest expectation.
// Registers are only written when the unit has drained.
module testbench;
	import ddo_pkg::*;

	// spare register index, writes to it must be ignored
	localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
	localparam int CordicIters = 16;
	// settle margin after drain, well over the time the unit takes per tick
	localparam int SettleCycles = 40;

	typedef struct {
		logic signed [31:0] right_count;
		logic signed [31:0] left_count;
		logic signed [23:0] right_speed;
		logic signed [23:0] left_speed;
	} tick_item_t;

	typedef struct {
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic [15:0]        head;
		logic signed [23:0] lin_speed;
		logic signed [31:0] ang_speed;
	} pose_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [31:0] right_count = '0;
	logic signed [31:0] left_count = '0;
	logic signed [23:0] right_speed = '0;
	logic signed [23:0] left_speed = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [31:0] x_position;
	logic signed [31:0] y_position;
	logic [15:0] heading;
	logic signed [23:0] linear_speed;
	logic signed [31:0] angular_speed;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	diff_drive_odometry_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.right_count(right_count), .left_count(left_count),
		.right_speed(right_speed), .left_speed(left_speed),
		.empty(empty), .pop(pop),
		.x_position(x_position), .y_position(y_position), .heading(heading),
		.linear_speed(linear_speed), .angular_speed(angular_speed),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// predictor copy of registers and pose state
	logic [31:0] dist_pulse, turns_dist, inv_base;
	logic [31:0] prev_right, prev_left;
	logic [31:0] pose_x_m, pose_y_m;
	logic [15:0] pose_head_m;

	// atan(2^-i) in units of 2^-32 turn
	logic [31:0] atan_step [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

	tick_item_t   pending_ticks[$];
	pose_result_t expected_poses[$];
	tick_item_t   offered;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int poses_checked = 0;
	logic stall_start = 1'b0;
	int stall_left = 0;
	logic [31:0] gen_right = '0, gen_left = '0;

	// advance the pose by one tick and return the expected result
	function automatic pose_result_t advance_pose(tick_item_t t);
		logic [31:0] dr_u, dl_u, diff_u, ang_u, z32;
		longint dr, dl, x, y, z, dx, dy, cs, sn, lin, w;
		logic [63:0] prod, sum_dist, px, py;
		logic flip;
		pose_result_t r;
		dr_u = t.right_count - prev_right;
		dl_u = t.left_count - prev_left;
		dr = longint'($signed(dr_u));
		dl = longint'($signed(dl_u));
		prev_right = t.right_count;
		prev_left = t.left_count;
		diff_u = dl_u - dr_u;
		prod = {32'b0, diff_u} * {32'b0, dist_pulse};
		prod = {32'b0, prod[31:0]} * {32'b0, turns_dist};
		pose_head_m = pose_head_m + prod[31:16];
		// cordic rotation, second and third quadrants folded by a half turn
		ang_u = {pose_head_m, 16'b0};
		flip = (ang_u[31:30] == 2'd1) || (ang_u[31:30] == 2'd2);
		if (flip)
			ang_u = ang_u - 32'h80000000;
		z32 = ang_u;
		z = longint'($signed(z32));
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < CordicIters; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - longint'({32'b0, atan_step[i]});
			end else begin
				x = x + dx; y = y - dy; z = z + longint'({32'b0, atan_step[i]});
			end
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
		sum_dist = dr + dl;
		sum_dist = sum_dist * {32'b0, dist_pulse};
		px = sum_dist * cs;
		py = sum_dist * sn;
		pose_x_m = pose_x_m + px[62:31];
		pose_y_m = pose_y_m + py[62:31];
		lin = (longint'(t.right_speed) + longint'(t.left_speed)) >>> 1;
		w = (longint'(t.right_speed) - longint'(t.left_speed)) * longint'({32'b0, inv_base});
		w = w >>> 16;
		if (w > 64'sd2147483647)
			w = 64'sd2147483647;
		if (w < -64'sd2147483648)
			w = -64'sd2147483648;
		r.x_pos = pose_x_m;
		r.y_pos = pose_y_m;
		r.head = pose_head_m;
		r.lin_speed = lin[23:0];
		r.ang_speed = w[31:0];
		return r;
	endfunction

	// driver: predict on each transfer, then offer the next tick or idle
	always @(posedge clk) begin
		if (push && !full)
			expected_poses.push_back(advance_pose(offered));
		if (!push || !full) begin
			if (pending_ticks.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				offered = pending_ticks.pop_front();
				right_count <= offered.right_count;
				left_count <= offered.left_count;
				right_speed <= offered.right_speed;
				left_speed <= offered.left_speed;
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (stall_start)
			stall_left <= 600;
		else if (stall_left > 0)
			stall_left <= stall_left - 1;
	end

	// monitor: check each popped result against the oldest expectation
	always @(posedge clk) begin
		pose_result_t e;
		if (pop && !empty) begin
			if (expected_poses.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatches++;
			end else begin
				e = expected_poses.pop_front();
				poses_checked++;
				if (x_position !== e.x_pos) begin
					$error("x_position exp %0d got %0d", e.x_pos, x_position);
					mismatches++;
				end
				if (y_position !== e.y_pos) begin
					$error("y_position exp %0d got %0d", e.y_pos, y_position);
					mismatches++;
				end
				if (heading !== e.head) begin
					$error("heading exp %0d got %0d", e.head, heading);
					mismatches++;
				end
				if (linear_speed !== e.lin_speed) begin
					$error("linear_speed exp %0d got %0d", e.lin_speed, linear_speed);
					mismatches++;
				end
				if (angular_speed !== e.ang_speed) begin
					$error("angular_speed exp %0d got %0d", e.ang_speed, angular_speed);
					mismatches++;
				end
			end
		end
		pop <= !stall_start && stall_left == 0 && $urandom_range(99) >= recv_stall_pct;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			RegDistPerPulse: dist_pulse = val;
			RegTurnsPerDist: turns_dist = val;
			RegInvWheelBase: inv_base = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_tick(input logic [31:0] rc, input logic [31:0] lc,
			input logic [23:0] rs, input logic [23:0] ls);
		tick_item_t t;
		t.right_count = rc;
		t.left_count = lc;
		t.right_speed = rs;
		t.left_speed = ls;
		pending_ticks.push_back(t);
		gen_right = rc;
		gen_left = lc;
	endtask

	// mostly steady motion with small count steps, some jumps and wild speeds
	task automatic queue_random(input int n);
		logic [31:0] rc, lc;
		logic [23:0] rs, ls;
		repeat (n) begin
			rc = gen_right + 32'($urandom_range(0, 4000)) - 32'd2000;
			lc = gen_left + 32'($urandom_range(0, 4000)) - 32'd2000;
			if ($urandom_range(99) < 12)
				rc = $urandom;
			if ($urandom_range(99) < 12)
				lc = $urandom;
			rs = 24'($urandom_range(0, 262144)) - 24'd131072;
			ls = 24'($urandom_range(0, 262144)) - 24'd131072;
			if ($urandom_range(99) < 30) begin
				rs = 24'($urandom);
				ls = 24'($urandom);
			end
			queue_tick(rc, lc, rs, ls);
		end
	endtask

	// wait for all transfers to complete, then let the unit settle
	task automatic drain;
		while (pending_ticks.size() > 0 || push || expected_poses.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_regs(input logic [31:0] dpp, input logic [31:0] tpd,
			input logic [31:0] iwb);
		write_reg(RegDistPerPulse, dpp);
		write_reg(RegTurnsPerDist, tpd);
		write_reg(RegInvWheelBase, iwb);
	endtask

	initial begin
		dist_pulse = 32'd65;
		turns_dist = 32'd65536;
		inv_base = 32'd327680;
		prev_right = '0;
		prev_left = '0;
		pose_x_m = '0;
		pose_y_m = '0;
		pose_head_m = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: first tick against zero counts, extremes, wraparound
		queue_tick(32'd0, 32'd0, 24'd0, 24'd0);
		queue_tick(32'd1000, 32'd1000, 24'h7FFFFF, 24'h7FFFFF);
		queue_tick(32'd1000, 32'd3000, 24'h800000, 24'h800000);
		queue_tick(32'h7FFFFFFF, 32'h80000000, 24'h7FFFFF, 24'h800000);
		queue_tick(32'h80000000, 32'h7FFFFFFF, 24'h800000, 24'h7FFFFF);
		queue_tick(32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'h000001);
		queue_tick(32'h00000005, 32'h00000003, 24'h000001, 24'hFFFFFF);
		queue_tick(32'h00000005, 32'h00010000, 24'h123456, 24'h654321);
		queue_tick(32'h00008005, 32'h00010000, 24'h0, 24'h0);
		queue_tick(32'hFFFF0000, 32'h0000FFFF, 24'hAAAAAA, 24'h555555);
		drain();
		// saturation of the angular speed, spare index must be ignored
		set_regs(32'd65, 32'd65536, 32'hFFFFFFFF);
		write_reg(RegSpare, 32'hDEADBEEF);
		queue_tick(32'h0000FFFF, 32'h0000FFFF, 24'h7FFFFF, 24'h800000);
		queue_tick(32'h0001FFFF, 32'h0000FFFF, 24'h800000, 24'h7FFFFF);
		queue_tick(32'h0001FFFF, 32'h0001FFFF, 24'h000100, 24'hFFFF00);
		drain();

		// random phases over several register settings and idle patterns
		set_regs(32'd65, 32'd65536, 32'd327680);
		queue_random(100);
		drain();
		sender_idle_pct = 77;
		set_regs(32'd0, 32'd0, 32'd0);
		queue_random(100);
		drain();
		sender_idle_pct = 0;
		recv_stall_pct = 77;
		set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		queue_random(100);
		drain();
		sender_idle_pct = 31;
		recv_stall_pct = 31;
		set_regs($urandom, $urandom, $urandom);
		queue_random(100);
		drain();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		set_regs(32'h00000100, 32'h00002800, 32'h00030000);
		queue_random(100);
		drain();
		sender_idle_pct = 77;
		recv_stall_pct = 77;
		set_regs($urandom_range(0, 4096), $urandom, $urandom_range(0, 1 << 20));
		queue_random(100);
		drain();

		// receiver holds off while ticks keep coming, so the input backs up
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		set_regs(32'd200, 32'h00003000, 32'h00050000);
		queue_random(100);
		@(posedge clk);
		stall_start <= 1'b1;
		@(posedge clk);
		stall_start <= 1'b0;
		drain();

		$display("checked %0d poses over directed ticks and seven random phases", poses_checked);
		$display("register extremes, idle and stall patterns and a long hold-off covered");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#8ms;
		$display("timeout");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
